// ===== hdl/sarx_pkg.sv =====
// shared types, codes and constants for the sbox-add-rotate-xnor cipher
// no dependencies
package sarx_pkg;

    localparam int BLOCK_BYTES = 8;
    localparam int BYTE_W      = 8;
    localparam int ROT_BITS    = 16;
    localparam int SBOX_DEPTH  = 256;
    localparam int KEY_W       = 64;
    localparam int PLAN_W      = 12;
    localparam int STAGES      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam logic [PLAN_W-1:0] PLAN_RESET = 12'd1680;

    // item kinds
    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_ENC  = 2'd1,
        REQ_DEC  = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    // stage operations
    typedef enum logic [1:0] {
        OP_ROTXNOR = 2'd0,
        OP_XOR     = 2'd1,
        OP_ADD     = 2'd2,
        OP_PASS    = 2'd3
    } t_op;

    // key selects
    typedef enum logic [1:0] {
        KEY_ONE   = 2'd0,
        KEY_TWO   = 2'd1,
        KEY_THREE = 2'd2,
        KEY_ZERO  = 2'd3
    } t_keysel;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_ONE   = 2'd0,
        CFG_KEY_TWO   = 2'd1,
        CFG_KEY_THREE = 2'd2,
        CFG_PLAN      = 2'd3
    } t_cfg_idx;

    // control that travels with each item down the pipe
    typedef struct packed {
        logic              vld;
        t_req              req;
        logic [BYTE_W-1:0] idx;
        logic [BYTE_W-1:0] val;
    } t_ctl;

endpackage

// ===== hdl/sbox_add_rotate_xnor_block_cipher.sv =====
// Pipeline: three slots of two stages; the result strobe is taken from the last slot's output.
// Throughput: one item per cycle while busy is low; each slot's table reads use per-lane copies.
// Load items travel the pipe and write each slot's tables as they pass, so no result.
// Reset (synchronous, active low) clears valid bits and keys and sets the plan to PLAN_RESET;
// busy is high for one cycle after reset. Tables are undefined until loaded. The receiver cannot stall.
module sbox_add_rotate_xnor_block_cipher #(
    parameter int BLOCK_BYTES = sarx_pkg::BLOCK_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [1:0]                      i_req_type,
    input  logic [63:0]                     i_data_block,
    input  logic [7:0]                      i_table_index,
    input  logic [7:0]                      i_table_value,
    output logic                            o_result_valid,
    output logic [63:0]                     o_result_block,
    output logic                            o_was_decrypt,
    input  logic                            i_cfg_we,
    input  logic [sarx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sarx_pkg::KEY_W-1:0]      i_cfg_data
);

    localparam int W  = 8 * BLOCK_BYTES;
    localparam int NS = sarx_pkg::STAGES;

    logic [sarx_pkg::KEY_W-1:0]  r_key_one;
    logic [sarx_pkg::KEY_W-1:0]  r_key_two;
    logic [sarx_pkg::KEY_W-1:0]  r_key_three;
    logic [sarx_pkg::PLAN_W-1:0] r_plan;
    logic                        r_busy;
    logic                        w_launch;

    sarx_pkg::t_ctl              w_ctl [NS+1];
    logic [W-1:0]                w_blk [NS+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_one   <= '0;
            r_key_two   <= '0;
            r_key_three <= '0;
            r_plan      <= sarx_pkg::PLAN_RESET;
        end else if (i_cfg_we) begin
            unique case (sarx_pkg::t_cfg_idx'(i_cfg_index))
                sarx_pkg::CFG_KEY_ONE:   r_key_one   <= i_cfg_data;
                sarx_pkg::CFG_KEY_TWO:   r_key_two   <= i_cfg_data;
                sarx_pkg::CFG_KEY_THREE: r_key_three <= i_cfg_data;
                default:                 r_plan      <= i_cfg_data[sarx_pkg::PLAN_W-1:0];
            endcase
        end
    end

    // busy while reset is held and for the cycle after reset
    always_ff @(posedge i_clk) begin
        r_busy <= !i_rst_n;
    end
    assign o_busy = r_busy;

    // launch an item; ignored request kinds never enter
    assign w_launch = i_start && !r_busy &&
                      (sarx_pkg::t_req'(i_req_type) != sarx_pkg::REQ_NONE);

    assign w_ctl[0].vld = w_launch;
    assign w_ctl[0].req = sarx_pkg::t_req'(i_req_type);
    assign w_ctl[0].idx = i_table_index;
    assign w_ctl[0].val = i_table_value;
    assign w_blk[0]     = W'(i_data_block);

    // three keyed slots in a chain
    for (genvar s = 0; s < NS; s++) begin : g_slot
        sarx_slot #(
            .BLOCK_BYTES (BLOCK_BYTES),
            .SLOT        (s)
        ) u_slot (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key_one   (r_key_one),
            .i_key_two   (r_key_two),
            .i_key_three (r_key_three),
            .i_plan      (r_plan),
            .i_ctl       (w_ctl[s]),
            .i_blk       (w_blk[s]),
            .o_ctl       (w_ctl[s+1]),
            .o_blk       (w_blk[s+1])
        );
    end

    // result strobe for encrypt and decrypt items
    assign o_result_valid = w_ctl[NS].vld && (w_ctl[NS].req != sarx_pkg::REQ_LOAD);
    assign o_result_block = 64'(w_blk[NS]);
    assign o_was_decrypt  = (w_ctl[NS].req == sarx_pkg::REQ_DEC);

    // a result traces back to a launched block item
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(w_launch && (i_req_type != sarx_pkg::REQ_LOAD), 6))
        else $error("result without matching launch");

    // decrypt flag follows the launched request kind
    a_dec_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_was_decrypt == $past(i_req_type == sarx_pkg::REQ_DEC, 6)))
        else $error("decrypt flag mismatch");

    // pipe is empty while busy after reset
    a_busy_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_result_valid)
        else $error("result while busy");

endmodule

// ===== hdl/sarx_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module sarx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sarx_slot.sv =====
// one keyed cipher slot: premix and table read, then table result, inverse table and subtract, or premix
// depends on sarx_pkg and sarx_ram
module sarx_slot #(
    parameter int BLOCK_BYTES = sarx_pkg::BLOCK_BYTES,
    parameter int SLOT        = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [sarx_pkg::KEY_W-1:0]      i_key_one,
    input  logic [sarx_pkg::KEY_W-1:0]      i_key_two,
    input  logic [sarx_pkg::KEY_W-1:0]      i_key_three,
    input  logic [sarx_pkg::PLAN_W-1:0]     i_plan,
    input  sarx_pkg::t_ctl                  i_ctl,
    input  logic [8*BLOCK_BYTES-1:0]        i_blk,
    output sarx_pkg::t_ctl                  o_ctl,
    output logic [8*BLOCK_BYTES-1:0]        o_blk
);

    localparam int W       = 8 * BLOCK_BYTES;
    localparam int RB      = sarx_pkg::ROT_BITS;
    localparam int BW      = sarx_pkg::BYTE_W;
    localparam int ENC_LSB = 4 * SLOT;
    localparam int DEC_LSB = 4 * (sarx_pkg::STAGES - 1 - SLOT);

    logic [3:0]            w_field;
    sarx_pkg::t_op         w_op;
    logic                  w_inv;
    logic [W-1:0]          w_key;
    logic [W-1:0]          w_sum;
    logic [W-1:0]          w_pre;
    logic                  w_load;
    logic [W-1:0]          w_fwd_q;
    logic [W-1:0]          w_inv_q;
    logic [W-1:0]          w_fin;

    sarx_pkg::t_ctl        r_a_ctl;
    sarx_pkg::t_op         r_a_op;
    logic                  r_a_inv;
    logic [W-1:0]          r_a_key;
    logic [W-1:0]          r_a_pre;
    sarx_pkg::t_ctl        r_b_ctl;
    logic [W-1:0]          r_b_blk;

    // pick this slot's plan field: decrypt walks the plan backwards
    always_comb begin
        w_inv   = (i_ctl.req == sarx_pkg::REQ_DEC);
        w_field = w_inv ? i_plan[DEC_LSB +: 4] : i_plan[ENC_LSB +: 4];
        w_op    = sarx_pkg::t_op'(w_field[1:0]);
        unique case (sarx_pkg::t_keysel'(w_field[3:2]))
            sarx_pkg::KEY_ONE:   w_key = W'(i_key_one);
            sarx_pkg::KEY_TWO:   w_key = W'(i_key_two);
            sarx_pkg::KEY_THREE: w_key = W'(i_key_three);
            default:             w_key = '0;
        endcase
    end

    // premix: rotate-xnor, xor, or the block unchanged; the forward add addresses the forward table
    always_comb begin
        w_sum = i_blk + w_key;
        case (w_op)
            sarx_pkg::OP_ROTXNOR: begin
                if (w_inv) begin
                    w_pre = ~(i_blk ^ w_key);
                    w_pre = {w_pre[RB-1:0], w_pre[W-1:RB]};
                end else begin
                    w_pre = ~({i_blk[W-RB-1:0], i_blk[W-1:W-RB]} ^ w_key);
                end
            end
            sarx_pkg::OP_XOR: w_pre = i_blk ^ w_key;
            default:          w_pre = i_blk;
        endcase
    end

    assign w_load = i_ctl.vld && (i_ctl.req == sarx_pkg::REQ_LOAD);

    // per-lane table copies, written as a load passes this slot
    for (genvar j = 0; j < BLOCK_BYTES; j++) begin : g_lane
        sarx_ram #(
            .WIDTH (BW),
            .DEPTH (sarx_pkg::SBOX_DEPTH)
        ) u_fwd (
            .i_clk   (i_clk),
            .i_we    (w_load),
            .i_waddr (i_ctl.idx),
            .i_wdata (i_ctl.val),
            .i_raddr (w_sum[BW*j +: BW]),
            .o_rdata (w_fwd_q[BW*j +: BW])
        );
        sarx_ram #(
            .WIDTH (BW),
            .DEPTH (sarx_pkg::SBOX_DEPTH)
        ) u_inv (
            .i_clk   (i_clk),
            .i_we    (w_load),
            .i_waddr (i_ctl.val),
            .i_wdata (i_ctl.idx),
            .i_raddr (i_blk[BW*j +: BW]),
            .o_rdata (w_inv_q[BW*j +: BW])
        );
    end

    // first register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.vld <= 1'b0;
        end else begin
            r_a_ctl.vld <= i_ctl.vld;
        end
        r_a_ctl.req <= i_ctl.req;
        r_a_ctl.idx <= i_ctl.idx;
        r_a_ctl.val <= i_ctl.val;
        r_a_op      <= w_op;
        r_a_inv     <= w_inv;
        r_a_key     <= w_key;
        r_a_pre     <= w_pre;
    end

    // finish: table output, inverse table then subtract, or premix
    always_comb begin
        if (r_a_op == sarx_pkg::OP_ADD) begin
            w_fin = r_a_inv ? (w_inv_q - r_a_key) : w_fwd_q;
        end else begin
            w_fin = r_a_pre;
        end
    end

    // second register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl.vld <= 1'b0;
        end else begin
            r_b_ctl.vld <= r_a_ctl.vld;
        end
        r_b_ctl.req <= r_a_ctl.req;
        r_b_ctl.idx <= r_a_ctl.idx;
        r_b_ctl.val <= r_a_ctl.val;
        r_b_blk     <= w_fin;
    end

    assign o_ctl = r_b_ctl;
    assign o_blk = r_b_blk;

endmodule
